@@ rtl/core/rvl_pkg.sv @@
// Shared types and constants for the RVL depth stream decoder.
package rvl_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned NIBBLES      = 8;
    localparam int unsigned DEPTH_W      = 16;
    localparam int unsigned COUNT_W      = 21;
    localparam int unsigned GROUP_W      = 4;

    localparam logic [COUNT_W-1:0] MAX_FRAME_PIXELS = COUNT_W'(1048576);
    localparam logic [COUNT_W-1:0] RST_FRAME_PIXELS = COUNT_W'(307200);

    // Groups at or above this index add nothing to the value.
    localparam logic [GROUP_W-1:0] GROUP_LIMIT = GROUP_W'(11);
    localparam logic [GROUP_W-1:0] GROUP_MAX   = GROUP_W'(15);

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_ZEROS    = 2'd0,
        PH_NONZEROS = 2'd1,
        PH_DELTAS   = 2'd2
    } t_phase;

    // One queued word plus its per-nibble "value ends here" mask, first nibble in bit 7.
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [NIBBLES-1:0] stop;
    } t_q_entry;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_value;
        logic [COUNT_W-1:0] repeat_count;
        logic               last_in_word;
        logic               end_of_frame;
        logic               count_error;
    } t_result;

endpackage

@@ rtl/core/rvl_front.sv @@
// Front end: input handshake, nibble classification and the word queue.
module rvl_front
    import rvl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [WORD_W-1:0]    i_data_word,
    output logic                 o_q_valid,
    output t_q_entry             o_q_entry,
    input  logic                 i_q_pop
);

    t_q_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count,  n_count;
    logic                 push;
    logic                 pop;
    t_q_entry             entry;

    // Mark every nibble whose continuation bit is clear.
    always_comb begin
        entry.word = i_data_word;
        for (int j = 0; j < NIBBLES; j++) begin
            entry.stop[j] = ~i_data_word[4*j+3];
        end
    end

    assign o_stall   = (r_count == Q_CNT_W'(Q_DEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= entry;
        end
    end

endmodule

@@ rtl/core/rvl_back.sv @@
// Back end: nibble-serial value decode, run bookkeeping and result staging.
module rvl_back
    import rvl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    input  logic                 i_q_valid,
    input  t_q_entry             i_q_entry,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_result              o_result
);

    // decode state
    t_phase               r_phase,        n_phase;
    logic [WORD_W-1:0]    r_acc,          n_acc;
    logic [GROUP_W-1:0]   r_grp,          n_grp;
    logic [COUNT_W-1:0]   r_run_rem,      n_run_rem;
    logic [COUNT_W-1:0]   r_frame_rem,    n_frame_rem;
    logic [DEPTH_W-1:0]   r_prev,         n_prev;
    logic                 r_run_err,      n_run_err;
    logic [COUNT_W-1:0]   r_frame_pixels, n_frame_pixels;
    // word sequencing
    logic                 r_busy,         n_busy;
    logic [2:0]           r_nib,          n_nib;
    logic [WORD_W-1:0]    r_word,         n_word;
    logic [NIBBLES-1:0]   r_stop,         n_stop;
    // result staging
    logic                 r_pend_v,       n_pend_v;
    t_result              r_pend,         n_pend;
    logic                 r_out_v,        n_out_v;
    t_result              r_out,          n_out;

    logic [3:0]           nib;
    logic [5:0]           shamt;
    logic [WORD_W-1:0]    acc_sum;
    logic [GROUP_W-1:0]   grp_inc;
    logic [WORD_W-1:0]    value;
    logic                 over;
    logic [COUNT_W-1:0]   clamped;
    logic [DEPTH_W-1:0]   delta;
    logic [COUNT_W-1:0]   fr_dec;
    logic [COUNT_W-1:0]   fr_sub;
    logic [COUNT_W-1:0]   rr_dec;
    logic [DEPTH_W-1:0]   prev_add;
    logic [COUNT_W-1:0]   cfg_clamped;

    // candidate outcome of the current nibble
    t_phase               c_phase;
    logic [WORD_W-1:0]    c_acc;
    logic [GROUP_W-1:0]   c_grp;
    logic [COUNT_W-1:0]   c_run_rem;
    logic [COUNT_W-1:0]   c_frame_rem;
    logic [DEPTH_W-1:0]   c_prev;
    logic                 c_run_err;
    logic                 res_v;
    t_result              res;
    logic                 eof;

    logic                 out_free;
    logic                 step_go;
    logic                 word_end;
    logic                 pend_move;

    // datapath for one nibble
    always_comb begin
        nib      = r_word[WORD_W-1 -: 4];
        shamt    = {2'b00, r_grp} + {1'b0, r_grp, 1'b0};
        acc_sum  = r_acc;
        if (r_grp < GROUP_LIMIT) begin
            acc_sum = r_acc | ({{(WORD_W-3){1'b0}}, nib[2:0]} << shamt);
        end
        grp_inc  = (r_grp == GROUP_MAX) ? GROUP_MAX : r_grp + 1'b1;
        value    = acc_sum;
        over     = value > {{(WORD_W-COUNT_W){1'b0}}, r_frame_rem};
        clamped  = over ? r_frame_rem : value[COUNT_W-1:0];
        delta    = value[DEPTH_W:1] ^ {DEPTH_W{value[0]}};
        prev_add = r_prev + delta;
        fr_dec   = (r_frame_rem != '0) ? r_frame_rem - 1'b1 : r_frame_rem;
        rr_dec   = (r_run_rem != '0) ? r_run_rem - 1'b1 : r_run_rem;
        fr_sub   = r_frame_rem - clamped;
    end

    // value completion per phase
    always_comb begin
        c_phase     = r_phase;
        c_acc       = acc_sum;
        c_grp       = grp_inc;
        c_run_rem   = r_run_rem;
        c_frame_rem = r_frame_rem;
        c_prev      = r_prev;
        c_run_err   = r_run_err;
        res_v       = 1'b0;
        res         = '0;
        eof         = 1'b0;
        if (r_stop[NIBBLES-1]) begin
            c_acc = '0;
            c_grp = '0;
            unique case (r_phase)
                PH_NONZEROS: begin
                    if (value == '0) begin
                        c_phase = PH_ZEROS;
                    end else begin
                        c_run_err = over;
                        c_run_rem = clamped;
                        c_phase   = PH_DELTAS;
                    end
                end
                PH_DELTAS: begin
                    c_prev           = prev_add;
                    c_frame_rem      = fr_dec;
                    c_run_rem        = rr_dec;
                    eof              = (fr_dec == '0);
                    res_v            = 1'b1;
                    res.depth_value  = prev_add;
                    res.repeat_count = COUNT_W'(1);
                    res.end_of_frame = eof;
                    res.count_error  = r_run_err;
                    if (!eof && rr_dec == '0) begin
                        c_phase = PH_ZEROS;
                    end
                end
                default: begin
                    c_frame_rem      = fr_sub;
                    eof              = (fr_sub == '0);
                    res_v            = (clamped != '0);
                    res.repeat_count = clamped;
                    res.end_of_frame = eof;
                    res.count_error  = over;
                    if (!eof) begin
                        c_phase = PH_NONZEROS;
                    end
                end
            endcase
            // frame complete: restart decode, drop the rest of the word
            if (eof) begin
                c_acc       = '0;
                c_grp       = '0;
                c_phase     = PH_ZEROS;
                c_run_rem   = '0;
                c_run_err   = 1'b0;
                c_prev      = '0;
                c_frame_rem = r_frame_pixels;
            end
        end
        res.last_in_word = 1'b0;
    end

    // handshake and staging control
    always_comb begin
        out_free  = !r_out_v || !i_stall;
        step_go   = r_busy && (!res_v || !r_pend_v || out_free);
        word_end  = step_go && ((r_nib == 3'd7) || eof);
        pend_move = r_pend_v && out_free && (r_pend.last_in_word || (step_go && res_v));
        o_q_pop   = i_q_valid && (!r_busy || word_end);
    end

    always_comb begin
        cfg_clamped = i_cfg_data;
        if (i_cfg_data == '0) begin
            cfg_clamped = COUNT_W'(1);
        end else if (i_cfg_data > MAX_FRAME_PIXELS) begin
            cfg_clamped = MAX_FRAME_PIXELS;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_acc          = r_acc;
        n_grp          = r_grp;
        n_run_rem      = r_run_rem;
        n_frame_rem    = r_frame_rem;
        n_prev         = r_prev;
        n_run_err      = r_run_err;
        n_frame_pixels = r_frame_pixels;
        n_busy         = r_busy;
        n_nib          = r_nib;
        n_word         = r_word;
        n_stop         = r_stop;
        n_pend_v       = r_pend_v;
        n_pend         = r_pend;
        n_out_v        = r_out_v;
        n_out          = r_out;

        if (i_cfg_we) begin
            n_frame_pixels = cfg_clamped;
            n_phase        = PH_ZEROS;
            n_acc          = '0;
            n_grp          = '0;
            n_run_rem      = '0;
            n_run_err      = 1'b0;
            n_prev         = '0;
            n_frame_rem    = cfg_clamped;
        end else if (step_go) begin
            n_phase     = c_phase;
            n_acc       = c_acc;
            n_grp       = c_grp;
            n_run_rem   = c_run_rem;
            n_frame_rem = c_frame_rem;
            n_prev      = c_prev;
            n_run_err   = c_run_err;
        end

        // advance through the word, load the next one at its end
        if (o_q_pop) begin
            n_busy = 1'b1;
            n_nib  = '0;
            n_word = i_q_entry.word;
            n_stop = i_q_entry.stop;
        end else if (word_end) begin
            n_busy = 1'b0;
        end else if (step_go) begin
            n_nib  = r_nib + 1'b1;
            n_word = {r_word[WORD_W-5:0], 4'h0};
            n_stop = {r_stop[NIBBLES-2:0], 1'b0};
        end

        // hold one result back until it is known whether it ends the word
        if (step_go && res_v) begin
            n_pend_v            = 1'b1;
            n_pend              = res;
            n_pend.last_in_word = word_end;
        end else if (pend_move) begin
            n_pend_v = 1'b0;
        end else if (word_end && r_pend_v) begin
            n_pend.last_in_word = 1'b1;
        end

        if (pend_move) begin
            n_out_v = 1'b1;
            n_out   = r_pend;
        end else if (!i_stall) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_ZEROS;
            r_acc          <= '0;
            r_grp          <= '0;
            r_run_rem      <= '0;
            r_frame_rem    <= RST_FRAME_PIXELS;
            r_prev         <= '0;
            r_run_err      <= 1'b0;
            r_frame_pixels <= RST_FRAME_PIXELS;
            r_busy         <= 1'b0;
            r_nib          <= '0;
            r_pend_v       <= 1'b0;
            r_out_v        <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_acc          <= n_acc;
            r_grp          <= n_grp;
            r_run_rem      <= n_run_rem;
            r_frame_rem    <= n_frame_rem;
            r_prev         <= n_prev;
            r_run_err      <= n_run_err;
            r_frame_pixels <= n_frame_pixels;
            r_busy         <= n_busy;
            r_nib          <= n_nib;
            r_pend_v       <= n_pend_v;
            r_out_v        <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_stop <= n_stop;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

@@ rtl/core/rvl_depth_decoder_core.sv @@
// Top level of the RVL depth stream decoder: front queue plus nibble decode back end.
// Throughput: one nibble decoded per cycle in the back end while the result stages are free, so a
//   word is done after its eight nibbles, sooner when a frame completes mid-word; at most one result per cycle.
// Result path: a word passes the queue and the word register; each result then goes through the
//   hold stage and the output register to o_valid, the last of a word once its final nibble is done.
// Reset (synchronous, active low): queue empty, decode at frame start, no result pending,
//   frame length 307200 pixels.
module rvl_depth_decoder_core
    import rvl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: frame length in pixels
    input  logic                 i_cfg_we,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    // compressed word input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [WORD_W-1:0]    i_data_word,
    // decoded result output
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DEPTH_W-1:0]   o_depth_value,
    output logic [COUNT_W-1:0]   o_repeat_count,
    output logic                 o_last_in_word,
    output logic                 o_end_of_frame,
    output logic                 o_count_error
);

    logic      q_valid;
    t_q_entry  q_entry;
    logic      q_pop;
    t_result   result;

    // Front: take words, tag where each value ends, buffer two words so the
    // input keeps flowing while the back end works through a word.
    rvl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_word (i_data_word),
        .o_q_valid   (q_valid),
        .o_q_entry   (q_entry),
        .i_q_pop     (q_pop)
    );

    // Back: one nibble per cycle while not stalled, run and frame bookkeeping, delta accumulation.
    // A one-deep hold stage keeps the newest result until the next result or the
    // word end decides its last-in-word flag; an output register drives the port.
    rvl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_entry),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (result)
    );

    // Unpack the result transaction onto its field ports.
    assign o_depth_value  = result.depth_value;
    assign o_repeat_count = result.repeat_count;
    assign o_last_in_word = result.last_in_word;
    assign o_end_of_frame = result.end_of_frame;
    assign o_count_error  = result.count_error;

endmodule
